[hw/rtl/bfe_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the bloom filter engine.
package bfe_pkg;

   localparam int BFE_MAX_BITS   = 65536;
   localparam int BFE_MAX_HASHES = 64;

   localparam int KIND_W     = 3;
   localparam int HASH_W     = 64;
   localparam int HASHES_W   = 7;
   localparam int SIZE_W     = 17;
   localparam int POP_W      = 17;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;

   localparam logic [HASHES_W-1:0] RESET_NUM_HASHES  = 7'd4;
   localparam logic [SIZE_W-1:0]   RESET_FILTER_BITS = 17'd65536;

   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FILL   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_INVERT = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_HASHES  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_BITS = 4'd1;

   typedef struct packed {
      logic take_item;
      logic probe_mul;
      logic probe_read;
      logic probe_check;
      logic sweep_start;
      logic word_write;
      logic word_fill;
      logic word_read;
      logic word_flip;
      logic pop_clear;
      logic pop_fill;
      logic pop_flip;
      logic wipe_ack;
      logic load_rsp;
   } bfe_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              last_probe;
      logic              last_word;
      logic              wipe_hold;
      logic              rsp_free;
   } bfe_status_type;

endpackage

[hw/rtl/bloom_filter_engine.sv]
// Bloom filter engine top level: double-hashing probes over a word-wide bit store.
// Insert/query: one probe is a multiply, an address/read and a check/write step on
// the bit store, repeated for each of the k hashes. Clear all and fill all write
// every store word once; invert all reads and rewrites each word in turn.
// Reset and every filter_bits write start a clearing pass over all STORE_WORDS words
// (1024 at default size) during which req_stall stays high.
module bloom_filter_engine
   import bfe_pkg::*;
#(
   parameter int MAX_BITS   = BFE_MAX_BITS,
   parameter int MAX_HASHES = BFE_MAX_HASHES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [HASH_W-1:0]     req_hash_high,
   input  logic [HASH_W-1:0]     req_hash_low,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_present,
   output logic [POP_W-1:0]      rsp_bits_set,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   bfe_cmd_type    cmd;
   bfe_status_type sts;

   bfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   bfe_dp #(
      .MAX_BITS   (MAX_BITS),
      .MAX_HASHES (MAX_HASHES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_kind      (req_kind),
      .req_hash_high (req_hash_high),
      .req_hash_low  (req_hash_low),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_present   (rsp_present),
      .rsp_bits_set  (rsp_bits_set),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_is_full   (rsp_is_full),
      .cmd           (cmd),
      .sts           (sts)
   );

endmodule

[hw/rtl/bfe_ctrl.sv]
// Sequencing state machine for the bloom filter engine: probes, store sweeps and result hand-off.
module bfe_ctrl
   import bfe_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  bfe_status_type sts,
   output bfe_cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_WIPE = 11'b000_0000_0010,
      S_DISP = 11'b000_0000_0100,
      S_PMUL = 11'b000_0000_1000,
      S_PRD  = 11'b000_0001_0000,
      S_PCHK = 11'b000_0010_0000,
      S_ZERO = 11'b000_0100_0000,
      S_FILL = 11'b000_1000_0000,
      S_IRD  = 11'b001_0000_0000,
      S_IWR  = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } bfe_state_type;

   bfe_state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE) || sts.wipe_hold;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (sts.wipe_hold) begin
               cmd.sweep_start = 1'b1;
               cmd.wipe_ack    = 1'b1;
               state_in        = S_WIPE;
            end else if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = S_DISP;
            end
         end
         S_WIPE: begin
            cmd.word_write = 1'b1;
            if (sts.last_word) begin
               cmd.pop_clear = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DISP: begin
            case (sts.kind)
               KIND_INSERT, KIND_QUERY: state_in = S_PMUL;
               KIND_CLEAR: begin
                  cmd.sweep_start = 1'b1;
                  state_in        = S_ZERO;
               end
               KIND_FILL: begin
                  cmd.sweep_start = 1'b1;
                  state_in        = S_FILL;
               end
               KIND_INVERT: begin
                  cmd.sweep_start = 1'b1;
                  state_in        = S_IRD;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_PMUL: begin
            cmd.probe_mul = 1'b1;
            state_in      = S_PRD;
         end
         S_PRD: begin
            cmd.probe_read = 1'b1;
            state_in       = S_PCHK;
         end
         S_PCHK: begin
            cmd.probe_check = 1'b1;
            state_in        = sts.last_probe ? S_DONE : S_PMUL;
         end
         S_ZERO: begin
            cmd.word_write = 1'b1;
            if (sts.last_word) begin
               cmd.pop_clear = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_FILL: begin
            cmd.word_write = 1'b1;
            cmd.word_fill  = 1'b1;
            if (sts.last_word) begin
               cmd.pop_fill = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_IRD: begin
            cmd.word_read = 1'b1;
            state_in      = S_IWR;
         end
         S_IWR: begin
            cmd.word_flip = 1'b1;
            if (sts.last_word) begin
               cmd.pop_flip = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_IRD;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/bfe_dp.sv]
// Datapath of the bloom filter engine: config registers, probe arithmetic, bit store, count, result.
module bfe_dp
   import bfe_pkg::*;
#(
   parameter int MAX_BITS   = BFE_MAX_BITS,
   parameter int MAX_HASHES = BFE_MAX_HASHES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic [HASH_W-1:0]     req_hash_high,
   input  logic [HASH_W-1:0]     req_hash_low,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_present,
   output logic [POP_W-1:0]      rsp_bits_set,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full,
   input  bfe_cmd_type           cmd,
   output bfe_status_type        sts
);

   localparam int STORE_WORDS = (MAX_BITS + 63) / 64;
   localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int PROD_W      = 32 + SIZE_W;

   logic [HASHES_W-1:0] num_hashes_ff, num_hashes_in;
   logic [SIZE_W-1:0]   filter_bits_ff, filter_bits_in;
   logic                wipe_ff, wipe_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [HASH_W-1:0]   stride_ff, stride_in;
   logic [HASH_W-1:0]   probe_ff, probe_in;
   logic [HASHES_W-1:0] cnt_ff, cnt_in;
   logic                all_ff, all_in;
   logic [PROD_W-1:0]   hi_prod_ff, hi_prod_in;
   logic [SIZE_W-1:0]   lo_carry_ff, lo_carry_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [5:0]          bit_ff, bit_in;
   logic [AW-1:0]       word_ff, word_in;
   logic [POP_W-1:0]    pop_ff, pop_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                present_ff;
   logic [POP_W-1:0]    bits_set_ff;
   logic                empty_ff, full_ff;

   logic [63:0]         store_ff [STORE_WORDS];
   logic [63:0]         rd_ff;

   logic [SIZE_W-1:0]   eff_size;
   logic [HASHES_W-1:0] eff_k;
   logic                size_write;
   logic [PROD_W-1:0]   lo_prod;
   logic [PROD_W-1:0]   mid_sum;
   logic [SIZE_W-1:0]   idx;
   logic                hit;
   logic                probe_we;
   logic                mem_we, mem_re;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   logic [63:0]         mem_wdata;
   logic [63:0]         sweep_mask;
   logic [10:0]         full_words;
   logic [5:0]          rest_bits;

   always_comb begin
      if (filter_bits_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (32'(filter_bits_ff) > MAX_BITS) begin
         eff_size = SIZE_W'(MAX_BITS);
      end else begin
         eff_size = filter_bits_ff;
      end
      if (num_hashes_ff == '0) begin
         eff_k = HASHES_W'(1);
      end else if (32'(num_hashes_ff) > MAX_HASHES) begin
         eff_k = HASHES_W'(MAX_HASHES);
      end else begin
         eff_k = num_hashes_ff;
      end
   end

   assign size_write = csr_we && (csr_index == REG_FILTER_BITS);

   // probe index = (probe * size) >> 64, split into two 32 x 17 products
   assign lo_prod = {{SIZE_W{1'b0}}, probe_ff[31:0]} * {32'b0, eff_size};
   assign mid_sum = hi_prod_ff + {32'b0, lo_carry_ff};
   assign idx     = mid_sum[PROD_W-1:32];
   assign hit     = rd_ff[bit_ff];
   assign probe_we = cmd.probe_check && (kind_ff == KIND_INSERT) && !hit;

   assign full_words = eff_size[16:6];
   assign rest_bits  = eff_size[5:0];

   always_comb begin
      if (32'(word_ff) < 32'(full_words)) begin
         sweep_mask = '1;
      end else if ((32'(word_ff) == 32'(full_words)) && (rest_bits != '0)) begin
         sweep_mask = (64'd1 << rest_bits) - 64'd1;
      end else begin
         sweep_mask = '0;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = word_ff;
      mem_wdata = '0;
      if (probe_we) begin
         mem_we    = 1'b1;
         mem_waddr = addr_ff;
         mem_wdata = rd_ff | (64'd1 << bit_ff);
      end else if (cmd.word_write) begin
         mem_we    = 1'b1;
         mem_wdata = cmd.word_fill ? sweep_mask : '0;
      end else if (cmd.word_flip) begin
         mem_we    = 1'b1;
         mem_wdata = rd_ff ^ sweep_mask;
      end
      mem_re    = cmd.probe_read || cmd.word_read;
      mem_raddr = cmd.probe_read ? AW'(idx >> 6) : word_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= store_ff[mem_raddr];
      end
   end

   always_comb begin
      num_hashes_in  = num_hashes_ff;
      filter_bits_in = filter_bits_ff;
      if (csr_we && (csr_index == REG_NUM_HASHES)) begin
         num_hashes_in = csr_wdata[HASHES_W-1:0];
      end
      if (size_write) begin
         filter_bits_in = csr_wdata[SIZE_W-1:0];
      end
      wipe_in = size_write ? 1'b1 : (cmd.wipe_ack ? 1'b0 : wipe_ff);

      kind_in     = kind_ff;
      stride_in   = stride_ff;
      probe_in    = probe_ff;
      cnt_in      = cnt_ff;
      all_in      = all_ff;
      hi_prod_in  = hi_prod_ff;
      lo_carry_in = lo_carry_ff;
      addr_in     = addr_ff;
      bit_in      = bit_ff;
      word_in     = word_ff;
      pop_in      = pop_ff;

      if (cmd.take_item) begin
         kind_in   = req_kind;
         stride_in = req_hash_low;
         probe_in  = req_hash_high;
         cnt_in    = '0;
         all_in    = 1'b1;
      end
      if (cmd.probe_mul) begin
         hi_prod_in  = {{SIZE_W{1'b0}}, probe_ff[63:32]} * {32'b0, eff_size};
         lo_carry_in = lo_prod[PROD_W-1:32];
      end
      if (cmd.probe_read) begin
         addr_in = AW'(idx >> 6);
         bit_in  = idx[5:0];
      end
      if (cmd.probe_check) begin
         probe_in = probe_ff + stride_ff;
         cnt_in   = cnt_ff + HASHES_W'(1);
         if (!hit && (kind_ff == KIND_QUERY)) begin
            all_in = 1'b0;
         end
         if (probe_we) begin
            pop_in = pop_ff + POP_W'(1);
         end
      end
      if (cmd.sweep_start) begin
         word_in = '0;
      end else if (cmd.word_write || cmd.word_flip) begin
         word_in = word_ff + AW'(1);
      end
      if (cmd.pop_clear || size_write) begin
         pop_in = '0;
      end else if (cmd.pop_fill) begin
         pop_in = eff_size;
      end else if (cmd.pop_flip) begin
         pop_in = eff_size - pop_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_hashes_ff  <= RESET_NUM_HASHES;
         filter_bits_ff <= RESET_FILTER_BITS;
         wipe_ff        <= 1'b1;
         pop_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         num_hashes_ff  <= num_hashes_in;
         filter_bits_ff <= filter_bits_in;
         wipe_ff        <= wipe_in;
         pop_ff         <= pop_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      stride_ff   <= stride_in;
      probe_ff    <= probe_in;
      cnt_ff      <= cnt_in;
      all_ff      <= all_in;
      hi_prod_ff  <= hi_prod_in;
      lo_carry_ff <= lo_carry_in;
      addr_ff     <= addr_in;
      bit_ff      <= bit_in;
      word_ff     <= word_in;
      if (cmd.load_rsp) begin
         present_ff  <= (kind_ff == KIND_QUERY) && all_ff;
         bits_set_ff <= pop_ff;
         empty_ff    <= (pop_ff == '0);
         full_ff     <= (pop_ff == eff_size);
      end
   end

   assign sts.kind       = kind_ff;
   assign sts.last_probe = (cnt_ff == (eff_k - HASHES_W'(1)));
   assign sts.last_word  = (word_ff == AW'(STORE_WORDS - 1));
   assign sts.wipe_hold  = wipe_ff || size_write;
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_present  = present_ff;
   assign rsp_bits_set = bits_set_ff;
   assign rsp_is_empty = empty_ff;
   assign rsp_is_full  = full_ff;

`ifndef SYNTH
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while still pending");

   a_pop_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pop_ff) <= 32'(eff_size))
      else $error("population above filter size");

   a_waddr_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < STORE_WORDS))
      else $error("store write beyond last word");
`endif

endmodule

[tb/bloom_filter_engine_test.sv]
// Self-checking testbench for bloom_filter_engine: directed table, then random phases per register setting.
module bloom_filter_engine_test
   import bfe_pkg::*;
();

   localparam logic [KIND_W-1:0] KIND_RSVD_LO  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_RSVD_MID = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RSVD_HI  = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_FIRST_UNUSED = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LAST_INDEX   = 4'd15;
   localparam int STORE_WORDS    = BFE_MAX_BITS / 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 400;
   localparam logic [HASH_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic             present;
      logic [POP_W-1:0] bits_set;
      logic             is_empty;
      logic             is_full;
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [HASH_W-1:0] high;
      logic [HASH_W-1:0] low;
      logic              known;
      status_type        want;
   } dir_row_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] hashes_data;
      logic [CSR_DATA_W-1:0] size_data;
      logic                  size_write;
      logic [9:0]            items;
   } phase_type;

   localparam status_type NO_STATUS = '0;

   localparam dir_row_type OPENING_ROWS [21] = '{
      '{KIND_QUERY,    64'h0, 64'h0, 1'b1, '{1'b0, 17'd0, 1'b1, 1'b0}},
      '{KIND_INSERT,   64'h0, 64'h0, 1'b1, '{1'b0, 17'd1, 1'b0, 1'b0}},
      '{KIND_QUERY,    64'h0, 64'h0, 1'b1, '{1'b1, 17'd1, 1'b0, 1'b0}},
      '{KIND_INSERT,   ALL_ONES, ALL_ONES, 1'b0, NO_STATUS},
      '{KIND_INSERT,   ALL_ONES, ALL_ONES, 1'b0, NO_STATUS},
      '{KIND_QUERY,    ALL_ONES, ALL_ONES, 1'b0, NO_STATUS},
      '{KIND_QUERY,    64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, NO_STATUS},
      '{KIND_RSVD_LO,  64'h0, 64'h0, 1'b0, NO_STATUS},
      '{KIND_RSVD_MID, ALL_ONES, 64'h0, 1'b0, NO_STATUS},
      '{KIND_RSVD_HI,  64'h0, ALL_ONES, 1'b0, NO_STATUS},
      '{KIND_FILL,     64'h0, 64'h0, 1'b1, '{1'b0, 17'd65536, 1'b0, 1'b1}},
      '{KIND_QUERY,    64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1,
        '{1'b1, 17'd65536, 1'b0, 1'b1}},
      '{KIND_RSVD_HI,  ALL_ONES, ALL_ONES, 1'b1, '{1'b0, 17'd65536, 1'b0, 1'b1}},
      '{KIND_INVERT,   64'h0, 64'h0, 1'b1, '{1'b0, 17'd0, 1'b1, 1'b0}},
      '{KIND_INVERT,   64'h0, 64'h0, 1'b1, '{1'b0, 17'd65536, 1'b0, 1'b1}},
      '{KIND_CLEAR,    64'h0, 64'h0, 1'b1, '{1'b0, 17'd0, 1'b1, 1'b0}},
      '{KIND_INSERT,   64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, NO_STATUS},
      '{KIND_QUERY,    64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, NO_STATUS},
      '{KIND_INVERT,   64'h0, 64'h0, 1'b0, NO_STATUS},
      '{KIND_QUERY,    64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b0, NO_STATUS},
      '{KIND_QUERY,    64'h0, 64'h0, 1'b0, NO_STATUS}
   };

   localparam int NUM_PHASES = 9;
   localparam phase_type SETTINGS_PLAN [NUM_PHASES] = '{
      '{17'h1FF81, 17'd64,      1'b1, 10'd80},
      '{17'd64,    17'd1,       1'b1, 10'd40},
      '{17'd0,     17'd0,       1'b1, 10'd40},
      '{17'd127,   17'h1FFFF,   1'b1, 10'd80},
      '{17'h00583, 17'd100,     1'b1, 10'd90},
      '{17'd16,    17'd0,       1'b0, 10'd70},
      '{17'd5,     17'd37,      1'b1, 10'd80},
      '{17'd9,     17'd65536,   1'b1, 10'd80},
      '{17'd0,     17'd0,       1'b1, 10'd90}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind;
   logic [HASH_W-1:0]     req_hash_high;
   logic [HASH_W-1:0]     req_hash_low;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_present;
   logic [POP_W-1:0]      rsp_bits_set;
   logic                  rsp_is_empty;
   logic                  rsp_is_full;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // shadow copy of the filter
   logic [HASH_W-1:0]   shadow_words [STORE_WORDS];
   int unsigned         shadow_pop;
   logic [HASHES_W-1:0] shadow_hashes;
   logic [SIZE_W-1:0]   shadow_size;

   status_type        expected_status [$];
   logic [HASH_W-1:0] key_pool_high [$];
   logic [HASH_W-1:0] key_pool_low [$];
   status_type        oldest;
   int unsigned       errors = 0;
   int unsigned       items_sent = 0;
   int unsigned       results_seen = 0;
   int unsigned       sweeps_sent = 0;
   int unsigned       quiet_cycles = 0;
   logic              req_quiet = 1'b0;
   logic              rsp_quiet = 1'b0;

   bloom_filter_engine dut (.*);

   always #1 clock = ~clock;

   function automatic logic [HASH_W-1:0] live_mask(int unsigned w, int unsigned size);
      if (w < size / 64)
         return ALL_ONES;
      if (w == size / 64)
         return (64'd1 << (size % 64)) - 64'd1;
      return '0;
   endfunction

   function automatic void wipe_shadow();
      int unsigned w;
      for (w = 0; w < STORE_WORDS; w++)
         shadow_words[w] = '0;
      shadow_pop = 0;
   endfunction

   function automatic status_type bloom_apply(input logic [KIND_W-1:0] kind,
                                              input logic [HASH_W-1:0] base,
                                              input logic [HASH_W-1:0] stride);
      int unsigned size, k, i, w;
      logic [HASH_W-1:0] probe;
      logic [127:0] prod;
      logic [15:0] pos;
      logic all_set;
      status_type st;
      size = (shadow_size == 0) ? 1 :
             (shadow_size > BFE_MAX_BITS) ? BFE_MAX_BITS : int'(shadow_size);
      k = (shadow_hashes == 0) ? 1 :
          (shadow_hashes > BFE_MAX_HASHES) ? BFE_MAX_HASHES : int'(shadow_hashes);
      all_set = 1'b1;
      st = '0;
      case (kind)
         KIND_INSERT, KIND_QUERY: begin
            for (i = 0; i < k; i++) begin
               probe = base + HASH_W'(i) * stride;
               prod = 128'(probe) * 128'(size);
               pos = prod[79:64];
               if (!shadow_words[pos[15:6]][pos[5:0]]) begin
                  all_set = 1'b0;
                  if (kind == KIND_INSERT) begin
                     shadow_words[pos[15:6]][pos[5:0]] = 1'b1;
                     shadow_pop++;
                  end
               end
            end
            st.present = (kind == KIND_QUERY) && all_set;
         end
         KIND_CLEAR: wipe_shadow();
         KIND_FILL: begin
            for (w = 0; w < STORE_WORDS; w++)
               shadow_words[w] = live_mask(w, size);
            shadow_pop = size;
         end
         KIND_INVERT: begin
            for (w = 0; w < STORE_WORDS; w++)
               shadow_words[w] ^= live_mask(w, size);
            shadow_pop = size - shadow_pop;
         end
         default: ;
      endcase
      st.bits_set = shadow_pop[POP_W-1:0];
      st.is_empty = (shadow_pop == 0);
      st.is_full  = (shadow_pop == size);
      return st;
   endfunction

   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [HASH_W-1:0] high,
                            input logic [HASH_W-1:0] low, input logic known,
                            input status_type want);
      int unsigned gap;
      status_type predicted;
      gap = req_quiet ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_kind      = kind;
      req_hash_high = high;
      req_hash_low  = low;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = bloom_apply(kind, high, low);
      expected_status.push_back(known ? want : predicted);
      items_sent++;
      if (kind == KIND_CLEAR || kind == KIND_FILL || kind == KIND_INVERT)
         sweeps_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_status.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      if (index == REG_NUM_HASHES) begin
         shadow_hashes = data[HASHES_W-1:0];
      end else if (index == REG_FILTER_BITS) begin
         shadow_size = data[SIZE_W-1:0];
         wipe_shadow();
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_item();
      int unsigned roll, pick;
      logic [KIND_W-1:0] kind;
      logic [HASH_W-1:0] high, low;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         kind = KIND_INSERT;
      else if (roll < 80)
         kind = KIND_QUERY;
      else if (roll < 84)
         kind = KIND_CLEAR;
      else if (roll < 89)
         kind = KIND_FILL;
      else if (roll < 95)
         kind = KIND_INVERT;
      else
         kind = KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
      high = {$urandom(), $urandom()};
      low  = {$urandom(), $urandom()};
      case ($urandom_range(0, 15))
         0: high = '0;
         1: high = ALL_ONES;
         2: low = '0;
         3: low = ALL_ONES;
         default: ;
      endcase
      if (kind == KIND_QUERY && key_pool_high.size() != 0 && $urandom_range(0, 1)) begin
         pick = $urandom_range(0, key_pool_high.size() - 1);
         high = key_pool_high[pick];
         low  = key_pool_low[pick];
      end
      if (kind == KIND_INSERT) begin
         key_pool_high.push_back(high);
         key_pool_low.push_back(low);
         if (key_pool_high.size() > 64) begin
            void'(key_pool_high.pop_front());
            void'(key_pool_low.pop_front());
         end
      end
      send_item(kind, high, low, 1'b0, NO_STATUS);
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_status.size() == 0) begin
            $error("result with no item outstanding: bits_set %0d", rsp_bits_set);
            errors++;
         end else begin
            oldest = expected_status.pop_front();
            if (rsp_present !== oldest.present) begin
               $error("present: expected %0d, got %0d", oldest.present, rsp_present);
               errors++;
            end
            if (rsp_bits_set !== oldest.bits_set) begin
               $error("bits_set: expected %0d, got %0d", oldest.bits_set, rsp_bits_set);
               errors++;
            end
            if (rsp_is_empty !== oldest.is_empty) begin
               $error("is_empty: expected %0d, got %0d", oldest.is_empty, rsp_is_empty);
               errors++;
            end
            if (rsp_is_full !== oldest.is_full) begin
               $error("is_full: expected %0d, got %0d", oldest.is_full, rsp_is_full);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // result side: random stalls plus two long hold-offs
   initial begin : result_side
      int unsigned gap;
      int unsigned holds_done;
      holds_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_done < 2 && results_seen >= (holds_done + 1) * 200) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end
         gap = rsp_quiet ? 0 : $urandom_range(0, 16);
         if (gap != 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned p, n;
      phase_type ph;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = KIND_INSERT;
      req_hash_high = '0;
      req_hash_low  = '0;
      csr_we        = 1'b0;
      csr_index     = REG_NUM_HASHES;
      csr_wdata     = '0;
      shadow_hashes = RESET_NUM_HASHES;
      shadow_size   = RESET_FILTER_BITS;
      wipe_shadow();
      repeat (5) @(negedge clock);
      reset = 1'b0;

      foreach (OPENING_ROWS[r])
         send_item(OPENING_ROWS[r].kind, OPENING_ROWS[r].high, OPENING_ROWS[r].low,
                   OPENING_ROWS[r].known, OPENING_ROWS[r].want);

      for (p = 0; p < NUM_PHASES; p++) begin
         ph = SETTINGS_PLAN[p];
         if (p == NUM_PHASES - 1) begin
            ph.hashes_data = {10'($urandom()), 7'($urandom_range(1, BFE_MAX_HASHES))};
            ph.size_data   = 17'($urandom_range(1, 4096));
         end
         drain();
         csr_write(REG_NUM_HASHES, ph.hashes_data);
         csr_write(CSR_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_INDEX)),
                   CSR_DATA_W'($urandom()));
         if (ph.size_write)
            csr_write(REG_FILTER_BITS, ph.size_data);
         req_quiet = (p % 3 == 2);
         rsp_quiet = (p % 3 == 1);
         for (n = 0; n < ph.items; n++) begin
            if ($urandom_range(0, 39) == 0)
               drain();
            random_item();
         end
      end
      drain();
      repeat (8) @(negedge clock);

      $display("Sent %0d items (%0d whole-store sweeps) over %0d register settings.",
               items_sent, sweeps_sent, NUM_PHASES + 1);
      $display("Checked %0d results, %0d field mismatches.", results_seen, errors);
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/bfe_pkg.sv
hw/rtl/bfe_ctrl.sv
hw/rtl/bfe_dp.sv
hw/rtl/bloom_filter_engine.sv
tb/bloom_filter_engine_test.sv
